@@ src/plle_pkg.sv @@
// ----------------------------------------------------------------------------
// plle_pkg: shared definitions for the positional list engine
// Operation and status codes, the per-cell command set and the control
// bundle that is broadcast along the row of value cells.
// ----------------------------------------------------------------------------
package plle_pkg;

    // default sizing
    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // cell index width, sized for the largest supported pool of 64 entries
    localparam int MAX_IDX_W = 6;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_APPEND   = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_DEL_POS  = 3'd3,
        OP_LIST     = 3'd4
    } t_op;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_ROTATE = 2'd3
    } t_cell_cmd;

    // broadcast control: command and 0-based target cell
    typedef struct packed {
        t_cell_cmd              cmd;
        logic [MAX_IDX_W-1:0]   target;
    } t_cell_ctl;

endpackage

@@ src/plle_cell.sv @@
// ----------------------------------------------------------------------------
// plle_cell: one slot of the ordered value row
// Holds the value at list position IDX+1. On insert, cells at and beyond
// the target move one place towards the tail; on delete, cells at and
// beyond the target take their right-hand neighbour's value, and on rotate every cell does.
// ----------------------------------------------------------------------------
module plle_cell #(
    parameter int DATA_WIDTH = plle_pkg::DATA_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  plle_pkg::t_cell_ctl   i_ctl,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_new,
    output logic [DATA_WIDTH-1:0] o_value
);
    import plle_pkg::*;

    localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;

    // next value from own command and position relative to the target
    always_comb begin
        n_value = r_value;
        unique case (i_ctl.cmd)
            CMD_INSERT: begin
                if (MY_IDX == i_ctl.target) begin
                    n_value = i_new;
                end else if (MY_IDX > i_ctl.target) begin
                    n_value = i_left;
                end
            end
            CMD_DELETE: begin
                if (MY_IDX >= i_ctl.target) begin
                    n_value = i_right;
                end
            end
            CMD_ROTATE: n_value = i_right;
            default:    n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ src/positional_linked_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// positional_linked_list_engine_core: ordered list of signed values
// Input channel (i_in_valid / o_in_stall) carries operation, position and
// value; output channel (o_out_valid / i_out_stall) returns status, item
// value, item position, entry count and a last flag per result.
// The list lives in a ring of CAPACITY cells, cell k holding position k+1.
// Insert at head/tail/position and delete at position are done by every
// cell shifting at once: the result is registered together with the shift
// and a new item can be taken right after it unless the output stalls.
// List walks the ring by rotating it one cell per cycle while the receiver
// does not stall, for CAPACITY steps (so the order is restored at the end),
// emitting one result per entry in the first count steps.
// Reset empties the list and clears the output valid flag; stored values are
// not cleared. When the receiver stalls, the output register holds its
// transfer and the rotation pauses; o_in_stall stays high until the block
// is idle and the output register can take a new result.
// ----------------------------------------------------------------------------
module positional_linked_list_engine_core #(
    parameter int CAPACITY   = plle_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plle_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [plle_pkg::OP_W-1:0]     i_operation,
    input  logic [plle_pkg::POS_W-1:0]    i_position,
    input  logic signed [plle_pkg::VAL_W-1:0] i_value,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [plle_pkg::STATUS_W-1:0] o_status,
    output logic signed [plle_pkg::VAL_W-1:0] o_item_value,
    output logic [plle_pkg::POS_W-1:0]    o_item_position,
    output logic [plle_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                          o_last
);
    import plle_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [IW-1:0]         r_k;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [VAL_W-1:0]      r_item_value;
    logic [POS_W-1:0]      r_item_pos;
    logic [COUNT_W-1:0]    r_entry_count;
    logic                  r_last;

    logic                  w_out_free;
    logic                  w_in_accept;
    t_cell_ctl             w_ctl;
    logic                  w_emit;
    t_status               w_status;
    logic [VAL_W-1:0]      w_emit_value;
    logic [POS_W-1:0]      w_emit_pos;
    logic                  w_emit_last;
    logic [CW-1:0]         w_count_nx;
    logic                  w_go_list;
    logic [PW-1:0]         w_pos_x;
    logic [PW-1:0]         w_cnt_x;
    logic [PW-1:0]         w_k_inc;
    logic                  w_full;
    logic                  w_ins_range_ok;
    logic                  w_del_range_ok;
    logic [MAX_IDX_W-1:0]  w_pos_target;
    logic [DATA_WIDTH-1:0] w_new_value;
    logic [DATA_WIDTH-1:0] w_cell_val [CAPACITY];

    // handshake
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && w_out_free);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // range checks on widened operands
    assign w_pos_x        = PW'(i_position);
    assign w_cnt_x        = PW'(r_count);
    assign w_k_inc        = PW'(r_k) + PW'(1);
    assign w_full         = (r_count == CAP_CNT);
    assign w_ins_range_ok = (w_pos_x != '0) && (w_pos_x <= w_cnt_x + PW'(1));
    assign w_del_range_ok = (w_pos_x != '0) && (w_pos_x <= w_cnt_x);
    assign w_pos_target   = MAX_IDX_W'(i_position - POS_W'(1));
    assign w_new_value    = DATA_WIDTH'(i_value);

    // operation decode and list walk control
    always_comb begin
        w_ctl.cmd    = CMD_HOLD;
        w_ctl.target = '0;
        w_emit       = 1'b0;
        w_status     = ST_OK;
        w_emit_value = '0;
        w_emit_pos   = '0;
        w_emit_last  = 1'b1;
        w_count_nx   = r_count;
        w_go_list    = 1'b0;
        if (r_state == S_IDLE) begin
            if (w_in_accept) begin
                unique case (t_op'(i_operation))
                    OP_INS_HEAD, OP_APPEND, OP_INS_POS: begin
                        w_emit = 1'b1;
                        if (w_full) begin
                            w_status = ST_FULL;
                        end else if ((t_op'(i_operation) == OP_INS_POS)
                                     && !w_ins_range_ok) begin
                            w_status = ST_RANGE;
                        end else begin
                            w_ctl.cmd = CMD_INSERT;
                            if (t_op'(i_operation) == OP_INS_HEAD) begin
                                w_ctl.target = '0;
                            end else if (t_op'(i_operation) == OP_APPEND) begin
                                w_ctl.target = MAX_IDX_W'(r_count);
                            end else begin
                                w_ctl.target = w_pos_target;
                            end
                            w_count_nx = r_count + CW'(1);
                        end
                    end
                    OP_DEL_POS: begin
                        w_emit = 1'b1;
                        if (r_count == '0) begin
                            w_status = ST_EMPTY;
                        end else if (!w_del_range_ok) begin
                            w_status = ST_RANGE;
                        end else begin
                            w_ctl.cmd    = CMD_DELETE;
                            w_ctl.target = w_pos_target;
                            w_emit_value = VAL_W'($signed(
                                w_cell_val[w_pos_target[IW-1:0]]));
                            w_count_nx   = r_count - CW'(1);
                        end
                    end
                    OP_LIST: begin
                        if (r_count == '0) begin
                            w_emit   = 1'b1;
                            w_status = ST_EMPTY;
                        end else begin
                            w_go_list = 1'b1;
                        end
                    end
                    default: w_emit = 1'b0;
                endcase
            end
        end else if (w_out_free) begin
            // one rotation step; only the first count steps give a result
            w_ctl.cmd = CMD_ROTATE;
            if (PW'(r_k) < w_cnt_x) begin
                w_emit       = 1'b1;
                w_emit_value = VAL_W'($signed(w_cell_val[0]));
                w_emit_pos   = w_k_inc[POS_W-1:0];
                w_emit_last  = (w_k_inc == w_cnt_x);
            end
        end
    end

    // state, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= w_count_nx;
            unique case (r_state)
                S_IDLE: begin
                    if (w_go_list) begin
                        r_state <= S_LIST;
                        r_k     <= '0;
                    end
                end
                S_LIST: begin
                    if (w_out_free) begin
                        r_k <= r_k + IW'(1);
                        if (r_k == LAST_IDX) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_emit) begin
                r_out_valid   <= 1'b1;
                r_status      <= w_status;
                r_item_value  <= w_emit_value;
                r_item_pos    <= w_emit_pos;
                r_entry_count <= COUNT_W'(PW'(w_count_nx));
                r_last        <= w_emit_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ring of value cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plle_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  ((g == 0) ? '0 : w_cell_val[(g == 0) ? 0 : g - 1]),
            .i_right (w_cell_val[(g + 1) % CAPACITY]),
            .i_new   (w_new_value),
            .o_value (w_cell_val[g])
        );
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_item_value    = r_item_value;
    assign o_item_position = r_item_pos;
    assign o_entry_count   = r_entry_count;
    assign o_last          = r_last;

`ifndef SYNTH
    // the count never goes beyond the pool
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count beyond capacity");

    // a successful head insert grows the list by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_operation == OP_INS_HEAD) && !w_full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    // only a list walk gives results that are not the last
    a_nonlast_from_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (r_state == S_LIST))
        else $error("non-final result outside a list walk");

    // the walk ends after the final rotation step
    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LIST) && w_out_free && (r_k == LAST_IDX))
        |=> (r_state == S_IDLE))
        else $error("list walk did not finish");
`endif

endmodule
